/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the raycaster checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define GDR_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define GDR_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/gdr_pkg.sv */
// ---------------------------------------------------------------------------
// gdr_pkg
// Types, constants and codes shared by the grid raycaster modules.
// ---------------------------------------------------------------------------
`default_nettype none

package gdr_pkg;

  localparam int MAP_DIM      = 64;
  localparam int SCREEN_WIDTH = 1024;   // power of two

  localparam int IDXW       = $clog2(MAP_DIM);
  localparam int MAP_AW     = 2 * IDXW;
  localparam int MAP_DEPTH  = MAP_DIM * MAP_DIM;
  localparam int FRAC_W     = 16;
  localparam int POS_INT_W  = 6;
  localparam int POSW       = POS_INT_W + FRAC_W;
  localparam int VECW       = 19;
  localparam int DIMW       = 7;
  localparam int COLW       = 10;
  localparam int CELLW      = 6;
  localparam int DISTW      = 24;
  // signed map coordinate, room for -1 and the player's start cell
  localparam int CW         = ((IDXW > POS_INT_W) ? IDXW : POS_INT_W) + 2;
  localparam int CAMW       = 18;
  localparam int CAM_SH     = 17 - $clog2(SCREEN_WIDTH);
  localparam int RDW        = 20;
  localparam int DSRW       = 19;
  localparam int NUMW       = CW + FRAC_W + 1;
  localparam int DIVW       = CW + 32;
  localparam int MULW_A     = 19;
  localparam int MULW_B     = 25;
  localparam int MULW       = MULW_A + MULW_B;
  localparam int STEP_LIMIT = 4 * MAP_DIM + 8;
  localparam int STEPW      = $clog2(STEP_LIMIT + 1);

  localparam logic [DISTW-1:0] DMAX = '1;

  localparam int APB_AW = 5;
  localparam int REGW   = 3;

  localparam logic [REGW-1:0] REG_PLAYER_X   = 3'd0;
  localparam logic [REGW-1:0] REG_PLAYER_Y   = 3'd1;
  localparam logic [REGW-1:0] REG_VIEW_DIR_X = 3'd2;
  localparam logic [REGW-1:0] REG_VIEW_DIR_Y = 3'd3;
  localparam logic [REGW-1:0] REG_PLANE_X    = 3'd4;
  localparam logic [REGW-1:0] REG_PLANE_Y    = 3'd5;
  localparam logic [REGW-1:0] REG_MAP_W      = 3'd6;
  localparam logic [REGW-1:0] REG_MAP_H      = 3'd7;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  typedef struct packed {
    logic             command;
    logic [CELLW-1:0] cell_x;
    logic [CELLW-1:0] cell_y;
    logic             cell_is_wall;
    logic [COLW-1:0]  column;
  } request_t;

  typedef struct packed {
    logic [COLW-1:0]  ray_column;
    logic             wall_hit;
    logic             hit_side;
    logic [CELLW-1:0] hit_cell_x;
    logic [CELLW-1:0] hit_cell_y;
    logic [DISTW-1:0] wall_distance;
  } result_t;

  typedef struct packed {
    logic        [POSW-1:0] player_x;
    logic        [POSW-1:0] player_y;
    logic signed [VECW-1:0] view_dir_x;
    logic signed [VECW-1:0] view_dir_y;
    logic signed [VECW-1:0] camera_plane_x;
    logic signed [VECW-1:0] camera_plane_y;
    logic        [DIMW-1:0] map_width;
    logic        [DIMW-1:0] map_height;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RAY_X,
    S_RAY_Y,
    S_DDX_GO,
    S_DDX_WAIT,
    S_DDY_GO,
    S_DDY_WAIT,
    S_SD_X,
    S_SD_Y,
    S_STEP,
    S_CHECK,
    S_NUM,
    S_DIST_WAIT,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

/* rtl/gdr_ram.sv */
// ---------------------------------------------------------------------------
// gdr_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module gdr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/gdr_div.sv */
// ---------------------------------------------------------------------------
// gdr_div
// Restoring divider, one quotient bit per cycle, result saturated to Q8.16.
// ---------------------------------------------------------------------------
`default_nettype none

module gdr_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [gdr_pkg::DIVW-1:0]  dividend,
  input  wire logic [gdr_pkg::DSRW-1:0]  divisor,
  output      logic                      done,
  output      logic [gdr_pkg::DISTW-1:0] quotient
);
  import gdr_pkg::*;

  localparam int CNTW = $clog2(DIVW + 1);

  logic [DIVW-1:0] quo;
  logic [DSRW-1:0] rem;
  logic [DSRW-1:0] dsr;
  logic [CNTW-1:0] count;
  logic            busy;
  logic [DSRW:0]   trial;
  logic            fits;

  assign trial = {rem, quo[DIVW-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNTW'(DIVW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? DSRW'(trial - {1'b0, dsr}) : trial[DSRW-1:0];
      quo <= {quo[DIVW-2:0], fits};
    end
  end

  assign quotient = (|quo[DIVW-1:DISTW]) ? DMAX : quo[DISTW-1:0];

endmodule

`default_nettype wire

/* rtl/gdr_regs.sv */
// ---------------------------------------------------------------------------
// gdr_regs
// APB register file holding player position, view vectors and map size.
// ---------------------------------------------------------------------------
`default_nettype none

module gdr_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [gdr_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output      logic [31:0]                prdata,
  output      logic                       pready,
  output      gdr_pkg::cfg_t              cfg
);
  import gdr_pkg::*;

  logic            wr;
  logic [REGW-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.player_x       <= '0;
      cfg.player_y       <= '0;
      cfg.view_dir_x     <= VECW'(65536);
      cfg.view_dir_y     <= '0;
      cfg.camera_plane_x <= '0;
      cfg.camera_plane_y <= VECW'(43253);
      cfg.map_width      <= DIMW'(64);
      cfg.map_height     <= DIMW'(64);
    end else if (wr) begin
      case (idx)
        REG_PLAYER_X:   cfg.player_x       <= pwdata[POSW-1:0];
        REG_PLAYER_Y:   cfg.player_y       <= pwdata[POSW-1:0];
        REG_VIEW_DIR_X: cfg.view_dir_x     <= pwdata[VECW-1:0];
        REG_VIEW_DIR_Y: cfg.view_dir_y     <= pwdata[VECW-1:0];
        REG_PLANE_X:    cfg.camera_plane_x <= pwdata[VECW-1:0];
        REG_PLANE_Y:    cfg.camera_plane_y <= pwdata[VECW-1:0];
        REG_MAP_W:      cfg.map_width      <= pwdata[DIMW-1:0];
        REG_MAP_H:      cfg.map_height     <= pwdata[DIMW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PLAYER_X:   prdata = {{(32-POSW){1'b0}}, cfg.player_x};
      REG_PLAYER_Y:   prdata = {{(32-POSW){1'b0}}, cfg.player_y};
      REG_VIEW_DIR_X: prdata = 32'(cfg.view_dir_x);
      REG_VIEW_DIR_Y: prdata = 32'(cfg.view_dir_y);
      REG_PLANE_X:    prdata = 32'(cfg.camera_plane_x);
      REG_PLANE_Y:    prdata = 32'(cfg.camera_plane_y);
      REG_MAP_W:      prdata = {{(32-DIMW){1'b0}}, cfg.map_width};
      REG_MAP_H:      prdata = {{(32-DIMW){1'b0}}, cfg.map_height};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/grid_dda_raycaster.sv */
// ---------------------------------------------------------------------------
// grid_dda_raycaster
// DDA grid raycaster over a wall bitmap held in block RAM.
// ---------------------------------------------------------------------------
// Requests arrive on request_valid / request_stall with a request_t payload.
// A write request (command 0) stores one wall bit in the map RAM in the cycle
// it is taken and produces no result; the next request can follow at once.
// A cast request (command 1) produces one result_t on result_valid /
// result_stall. One cast at a time is in flight; request_stall is high while
// it runs. A cast walks at most map_width + map_height + 2 DDA steps; the two
// reciprocals and the final distance go through one shared bit-serial divider,
// and each step costs one map RAM read.
// The result sits in an output register, so the next request is accepted
// while it waits; a stalled result holds until taken, and a following cast
// waits at its end until the register frees.
// Reset clears the control state and loads the register defaults; the map
// contents are undefined until written. Registers are written over APB; the
// user must write them only while the block is idle; the block does not check.
// ---------------------------------------------------------------------------
`default_nettype none

module grid_dda_raycaster (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       request_valid,
  output      logic                       request_stall,
  input  wire gdr_pkg::request_t          request,
  output      logic                       result_valid,
  input  wire logic                       result_stall,
  output      gdr_pkg::result_t           result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [gdr_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output      logic [31:0]                prdata,
  output      logic                       pready
);
  import gdr_pkg::*;

  cfg_t   cfg;
  state_t state, state_next;

  logic                   accept;
  logic                   ram_we;
  logic [MAP_AW-1:0]      ram_waddr;
  logic [MAP_AW-1:0]      ram_raddr;
  logic                   ram_rdata;

  logic [COLW-1:0]        col;
  logic signed [CAMW-1:0] cam;
  logic signed [RDW-1:0]  rdx, rdy;
  logic [DISTW-1:0]       ddx, ddy, sdx, sdy;
  logic signed [CW-1:0]   mx, my, w_lim, h_lim;
  logic                   side;
  logic [STEPW-1:0]       steps;
  logic [DISTW-1:0]       wall_dist;
  logic                   hit;

  // shared multiplier
  logic signed [MULW_A-1:0] mul_a;
  logic signed [MULW_B-1:0] mul_b;
  logic signed [MULW-1:0]   prod;
  logic signed [RDW-1:0]    ray_val;
  logic [DISTW-1:0]         sd_val;
  logic [FRAC_W:0]          frac_x, frac_y;

  // divider
  logic                   div_start;
  logic [DIVW-1:0]        div_dividend;
  logic [DSRW-1:0]        div_divisor;
  logic                   div_done;
  logic [DISTW-1:0]       div_q;
  logic [RDW-1:0]         abs_rdx, abs_rdy;

  // walk
  logic                   step_x;
  logic [DISTW:0]         sdx_sum, sdy_sum;
  logic signed [CW-1:0]   mx_n, my_n;
  logic                   leave;

  // distance
  logic signed [NUMW-1:0] num;
  logic [NUMW-1:0]        abs_num;
  logic                   rd_neg, rd_zero, wrong_sign;

  logic                   load_result;

  gdr_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  gdr_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
    .clk,
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (request.cell_is_wall),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gdr_div u_div (
    .clk,
    .rst,
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign request_stall = (state != S_IDLE);
  assign accept        = request_valid && !request_stall;
  assign ram_we        = accept && (request.command == CMD_WRITE)
                         && (32'(request.cell_x) < MAP_DIM)
                         && (32'(request.cell_y) < MAP_DIM);
  assign ram_waddr     = {request.cell_y[IDXW-1:0], request.cell_x[IDXW-1:0]};

  // ---- multiplier operands ----
  assign frac_x = rdx[RDW-1] ? {1'b0, cfg.player_x[FRAC_W-1:0]}
                             : (FRAC_W+1)'(65536) - {1'b0, cfg.player_x[FRAC_W-1:0]};
  assign frac_y = rdy[RDW-1] ? {1'b0, cfg.player_y[FRAC_W-1:0]}
                             : (FRAC_W+1)'(65536) - {1'b0, cfg.player_y[FRAC_W-1:0]};

  always_comb begin
    case (state)
      S_RAY_X: begin
        mul_a = cfg.camera_plane_x;
        mul_b = MULW_B'(cam);
      end
      S_RAY_Y: begin
        mul_a = cfg.camera_plane_y;
        mul_b = MULW_B'(cam);
      end
      S_SD_X: begin
        mul_a = MULW_A'({1'b0, frac_x});
        mul_b = MULW_B'({1'b0, ddx});
      end
      S_SD_Y: begin
        mul_a = MULW_A'({1'b0, frac_y});
        mul_b = MULW_B'({1'b0, ddy});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // dir + floor(plane*cam / 2^16); arithmetic shift gives the floor
  always_comb begin
    logic signed [MULW-FRAC_W-1:0] dir_ext;
    dir_ext = (state == S_RAY_X) ? (MULW-FRAC_W)'(cfg.view_dir_x)
                                 : (MULW-FRAC_W)'(cfg.view_dir_y);
    ray_val = RDW'(dir_ext + prod[MULW-1:FRAC_W]);
  end

  assign sd_val = (|prod[MULW-1:FRAC_W+DISTW]) ? DMAX : prod[FRAC_W+DISTW-1:FRAC_W];

  // ---- divider operands ----
  assign abs_rdx = rdx[RDW-1] ? RDW'(-rdx) : RDW'(rdx);
  assign abs_rdy = rdy[RDW-1] ? RDW'(-rdy) : RDW'(rdy);

  // ---- DDA step ----
  assign step_x  = sdx < sdy;
  assign sdx_sum = {1'b0, sdx} + {1'b0, ddx};
  assign sdy_sum = {1'b0, sdy} + {1'b0, ddy};
  assign mx_n    = step_x ? (rdx[RDW-1] ? mx - CW'(1) : mx + CW'(1)) : mx;
  assign my_n    = step_x ? my : (rdy[RDW-1] ? my - CW'(1) : my + CW'(1));
  assign leave   = (mx_n < 0) || (mx_n >= w_lim) || (my_n < 0) || (my_n >= h_lim);
  assign ram_raddr = {my_n[IDXW-1:0], mx_n[IDXW-1:0]};

  // ---- perpendicular distance ----
  always_comb begin
    logic signed [NUMW-1:0] cell_q, pos_q, adj;
    if (!side) begin
      cell_q = {mx[CW-1], mx, {FRAC_W{1'b0}}};
      pos_q  = NUMW'({1'b0, cfg.player_x});
      adj    = rdx[RDW-1] ? NUMW'(65536) : '0;
      rd_neg = rdx[RDW-1];
      rd_zero = (rdx == '0);
    end else begin
      cell_q = {my[CW-1], my, {FRAC_W{1'b0}}};
      pos_q  = NUMW'({1'b0, cfg.player_y});
      adj    = rdy[RDW-1] ? NUMW'(65536) : '0;
      rd_neg = rdy[RDW-1];
      rd_zero = (rdy == '0);
    end
    num = cell_q - pos_q + adj;
  end

  assign abs_num    = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
  assign wrong_sign = (num != '0) && (num[NUMW-1] != rd_neg);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {{(DIVW-33){1'b0}}, 1'b1, 32'd0};
    div_divisor  = abs_rdx[DSRW-1:0];
    case (state)
      S_DDX_GO: div_start = (rdx != '0);
      S_DDY_GO: begin
        div_start   = (rdy != '0);
        div_divisor = abs_rdy[DSRW-1:0];
      end
      S_NUM: begin
        div_start    = !rd_zero && !wrong_sign;
        div_dividend = {abs_num[NUMW-2:0], {FRAC_W{1'b0}}};
        div_divisor  = side ? abs_rdy[DSRW-1:0] : abs_rdx[DSRW-1:0];
      end
      default: ;
    endcase
  end

  assign load_result = (state == S_FINISH) && (!result_valid || !result_stall);

  // ---- control ----
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (accept && request.command == CMD_CAST) state_next = S_RAY_X;
      S_RAY_X:     state_next = S_RAY_Y;
      S_RAY_Y:     state_next = S_DDX_GO;
      S_DDX_GO:    state_next = (rdx != '0) ? S_DDX_WAIT : S_DDY_GO;
      S_DDX_WAIT:  if (div_done) state_next = S_DDY_GO;
      S_DDY_GO:    state_next = (rdy != '0) ? S_DDY_WAIT : S_SD_X;
      S_DDY_WAIT:  if (div_done) state_next = S_SD_X;
      S_SD_X:      state_next = S_SD_Y;
      S_SD_Y:      state_next = S_STEP;
      S_STEP: begin
        if (steps == STEPW'(STEP_LIMIT) || leave) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_CHECK:     state_next = ram_rdata ? S_NUM : S_STEP;
      S_NUM:       state_next = (!rd_zero && !wrong_sign) ? S_DIST_WAIT : S_FINISH;
      S_DIST_WAIT: if (div_done) state_next = S_FINISH;
      S_FINISH:    if (load_result) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        col   <= request.column;
        cam   <= CAMW'({1'b0, request.column} << CAM_SH) - CAMW'(65536);
        mx    <= CW'(cfg.player_x[POSW-1:FRAC_W]);
        my    <= CW'(cfg.player_y[POSW-1:FRAC_W]);
        w_lim <= (32'(cfg.map_width) > MAP_DIM) ? CW'(MAP_DIM) : CW'(cfg.map_width);
        h_lim <= (32'(cfg.map_height) > MAP_DIM) ? CW'(MAP_DIM) : CW'(cfg.map_height);
        steps <= '0;
        hit   <= 1'b0;
        side  <= 1'b0;
        wall_dist <= '0;
        ddx   <= DMAX;
        ddy   <= DMAX;
      end
      S_RAY_X:    rdx <= ray_val;
      S_RAY_Y:    rdy <= ray_val;
      S_DDX_WAIT: if (div_done) ddx <= div_q;
      S_DDY_WAIT: if (div_done) ddy <= div_q;
      S_SD_X:     sdx <= (rdx == '0) ? DMAX : sd_val;
      S_SD_Y:     sdy <= (rdy == '0) ? DMAX : sd_val;
      S_STEP: begin
        if (steps != STEPW'(STEP_LIMIT)) begin
          steps <= steps + 1'b1;
          mx    <= mx_n;
          my    <= my_n;
          side  <= !step_x;
          if (step_x) begin
            sdx <= sdx_sum[DISTW] ? DMAX : sdx_sum[DISTW-1:0];
          end else begin
            sdy <= sdy_sum[DISTW] ? DMAX : sdy_sum[DISTW-1:0];
          end
        end
      end
      S_CHECK:    hit <= ram_rdata;
      S_NUM:      wall_dist <= rd_zero ? DMAX : '0;
      S_DIST_WAIT: if (div_done) wall_dist <= div_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.ray_column    <= col;
      result.wall_hit      <= hit;
      result.hit_side      <= hit ? side : 1'b0;
      result.hit_cell_x    <= hit ? mx[CELLW-1:0] : '0;
      result.hit_cell_y    <= hit ? my[CELLW-1:0] : '0;
      result.wall_distance <= hit ? wall_dist : '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/gdr_checker.sv */
// ---------------------------------------------------------------------------
// gdr_checker
// Port-level checks for the raycaster, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gdr_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              request_valid,
  input wire logic              request_stall,
  input wire gdr_pkg::request_t request,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire gdr_pkg::result_t  result
);
  import gdr_pkg::*;

  `GDR_ASSERT(a_hold, clk, rst, result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")

  `GDR_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid, "result valid after reset")

  `GDR_ASSERT(a_miss_zero, clk, rst, result_valid && !result.wall_hit |-> result.hit_side == 1'b0 && result.hit_cell_x == '0 && result.hit_cell_y == '0 && result.wall_distance == '0, "miss with nonzero fields")

  `GDR_ASSERT(a_write_silent, clk, rst, request_valid && !request_stall && request.command == CMD_WRITE && !result_valid |=> !result_valid, "map write produced a result")

endmodule

bind grid_dda_raycaster gdr_checker u_gdr_checker (.*);

`default_nettype wire

/* tb/grid_dda_raycaster_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_dda_raycaster_test
// Self-checking bench for the raycaster: fills the whole wall map, then
// casts directed and random rays under many camera and map settings and
// compares every result against an in-bench DDA predictor.
// ---------------------------------------------------------------------------

module grid_dda_raycaster_test;
  import gdr_pkg::*;

  localparam longint CYCLE_LIMIT = 8_000_000;
  localparam int     SETTLE      = 600;
  localparam longint SAT_MAX     = 64'hFFFFFF;
  localparam longint Q16_ONE     = 65536;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        request_valid = 1'b0;
  logic        request_stall;
  request_t    request = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  grid_dda_raycaster u_top (
    .clk, .rst, .request_valid, .request_stall, .request,
    .result_valid, .result_stall, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk = ~clk;

  // shadow of the camera and map registers
  logic        [POSW-1:0] sh_px, sh_py;
  logic signed [VECW-1:0] sh_dx, sh_dy, sh_plx, sh_ply;
  logic        [DIMW-1:0] sh_mw, sh_mh;
  bit                     wall_map [MAP_DEPTH];

  request_t pending_requests[$];
  result_t  due_rays[$];

  int     errors = 0;
  int     casts_taken = 0;
  int     cell_writes = 0;
  int     hits_seen = 0;
  int     rays_checked = 0;
  longint cycles = 0;
  bit     src_hold = 1'b0;
  bit     long_hold_done = 1'b0;
  int     sink_hold = 0;

  function automatic longint clamp_dist(longint v);
    return v > SAT_MAX ? SAT_MAX : (v < 0 ? 0 : v);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic result_t trace_ray(logic [COLW-1:0] col);
    longint cam, rdx, rdy, ddx, ddy, sdx, sdy, px, py, mx, my;
    longint w, h, stx, sty, num, rd, perp;
    int side, hit;
    result_t r;
    side = 0;
    hit = 0;
    cam = (longint'(col) * 131072) / SCREEN_WIDTH - Q16_ONE;
    rdx = longint'(sh_dx) + ((longint'(sh_plx) * cam) >>> 16);
    rdy = longint'(sh_dy) + ((longint'(sh_ply) * cam) >>> 16);
    px = longint'(sh_px);
    py = longint'(sh_py);
    mx = px / Q16_ONE;
    my = py / Q16_ONE;
    w = sh_mw > MAP_DIM ? MAP_DIM : longint'(sh_mw);
    h = sh_mh > MAP_DIM ? MAP_DIM : longint'(sh_mh);
    ddx = rdx == 0 ? SAT_MAX : clamp_dist((64'd1 << 32) / mag(rdx));
    ddy = rdy == 0 ? SAT_MAX : clamp_dist((64'd1 << 32) / mag(rdy));
    stx = rdx < 0 ? -1 : 1;
    sty = rdy < 0 ? -1 : 1;
    if (rdx == 0) sdx = SAT_MAX;
    else if (rdx < 0) sdx = clamp_dist(((px - mx * Q16_ONE) * ddx) / Q16_ONE);
    else sdx = clamp_dist((((mx + 1) * Q16_ONE - px) * ddx) / Q16_ONE);
    if (rdy == 0) sdy = SAT_MAX;
    else if (rdy < 0) sdy = clamp_dist(((py - my * Q16_ONE) * ddy) / Q16_ONE);
    else sdy = clamp_dist((((my + 1) * Q16_ONE - py) * ddy) / Q16_ONE);
    for (int n = 0; n < STEP_LIMIT; n++) begin
      if (sdx < sdy) begin
        sdx = clamp_dist(sdx + ddx);
        mx += stx;
        side = 0;
      end else begin
        sdy = clamp_dist(sdy + ddy);
        my += sty;
        side = 1;
      end
      if (mx < 0 || mx >= w || my < 0 || my >= h) break;
      if (wall_map[my * MAP_DIM + mx]) begin
        hit = 1;
        break;
      end
    end
    r = '0;
    r.ray_column = col;
    r.wall_hit = hit[0];
    if (hit) begin
      if (side == 0) begin
        num = mx * Q16_ONE - px + (stx < 0 ? Q16_ONE : 0);
        rd = rdx;
      end else begin
        num = my * Q16_ONE - py + (sty < 0 ? Q16_ONE : 0);
        rd = rdy;
      end
      if (rd == 0) perp = SAT_MAX;
      else if (num != 0 && ((num < 0) != (rd < 0))) perp = 0;
      else perp = clamp_dist((mag(num) << 16) / mag(rd));
      r.hit_side = side[0];
      r.hit_cell_x = mx[CELLW-1:0];
      r.hit_cell_y = my[CELLW-1:0];
      r.wall_distance = perp[DISTW-1:0];
    end
    return r;
  endfunction

  // driver: predicts each taken request, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      request_valid <= 1'b0;
    end else begin
      if (request_valid && !request_stall) begin
        if (request.command == CMD_WRITE) begin
          wall_map[request.cell_y * MAP_DIM + request.cell_x] = request.cell_is_wall;
          cell_writes++;
        end else begin
          due_rays.push_back(trace_ray(request.column));
          casts_taken++;
        end
      end
      if (!request_valid || !request_stall) begin
        if (pending_requests.size() > 0 && !src_hold &&
            ($urandom_range(0, 99) >= 12 || (cycles > 150000 && cycles < 350000))) begin
          request <= pending_requests.pop_front();
          request_valid <= 1'b1;
        end else begin
          request_valid <= 1'b0;
        end
      end
    end
  end

  // sink: random stall plus one long hold-off
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (!long_hold_done && rays_checked == 300) begin
        long_hold_done <= 1'b1;
        sink_hold <= 5000;
      end else if (sink_hold > 0) begin
        sink_hold <= sink_hold - 1;
      end
      result_stall <= (sink_hold > 1) ||
                      ($urandom_range(0, 99) < 12 && !(cycles > 150000 && cycles < 350000));
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (due_rays.size() == 0) begin
        $error("result with no ray pending: column %0d", result.ray_column);
        errors++;
      end else begin
        result_t exp_r;
        exp_r = due_rays.pop_front();
        if (result.ray_column !== exp_r.ray_column) begin
          $error("ray_column exp %0d got %0d", exp_r.ray_column, result.ray_column);
          errors++;
        end
        if (result.wall_hit !== exp_r.wall_hit) begin
          $error("wall_hit exp %0d got %0d", exp_r.wall_hit, result.wall_hit);
          errors++;
        end
        if (result.hit_side !== exp_r.hit_side) begin
          $error("hit_side exp %0d got %0d", exp_r.hit_side, result.hit_side);
          errors++;
        end
        if (result.hit_cell_x !== exp_r.hit_cell_x) begin
          $error("hit_cell_x exp %0d got %0d", exp_r.hit_cell_x, result.hit_cell_x);
          errors++;
        end
        if (result.hit_cell_y !== exp_r.hit_cell_y) begin
          $error("hit_cell_y exp %0d got %0d", exp_r.hit_cell_y, result.hit_cell_y);
          errors++;
        end
        if (result.wall_distance !== exp_r.wall_distance) begin
          $error("wall_distance exp %0h got %0h", exp_r.wall_distance, result.wall_distance);
          errors++;
        end
        if (exp_r.wall_hit) hits_seen++;
      end
      rays_checked++;
    end
  end

  task automatic reg_write(logic [REGW-1:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(idx) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PLAYER_X:   sh_px = v[POSW-1:0];
      REG_PLAYER_Y:   sh_py = v[POSW-1:0];
      REG_VIEW_DIR_X: sh_dx = v[VECW-1:0];
      REG_VIEW_DIR_Y: sh_dy = v[VECW-1:0];
      REG_PLANE_X:    sh_plx = v[VECW-1:0];
      REG_PLANE_Y:    sh_ply = v[VECW-1:0];
      REG_MAP_W:      sh_mw = v[DIMW-1:0];
      REG_MAP_H:      sh_mh = v[DIMW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_camera(int px, int py, int dx, int dy, int plx, int ply,
                            int mw, int mh);
    reg_write(REG_PLAYER_X, px);
    reg_write(REG_PLAYER_Y, py);
    reg_write(REG_VIEW_DIR_X, dx);
    reg_write(REG_VIEW_DIR_Y, dy);
    reg_write(REG_PLANE_X, plx);
    reg_write(REG_PLANE_Y, ply);
    reg_write(REG_MAP_W, mw);
    reg_write(REG_MAP_H, mh);
  endtask

  // source pauses until every ray is back, then lets the walk settle
  task automatic drain_rays();
    while (pending_requests.size() != 0 || request_valid || due_rays.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_cast(int col);
    request_t q;
    q = '0;
    q.command = CMD_CAST;
    q.column = col;
    q.cell_x = $urandom;
    q.cell_y = $urandom;
    q.cell_is_wall = $urandom;
    pending_requests.push_back(q);
  endtask

  task automatic queue_cell(int cx, int cy, bit wall);
    request_t q;
    q = '0;
    q.command = CMD_WRITE;
    q.cell_x = cx;
    q.cell_y = cy;
    q.cell_is_wall = wall;
    q.column = $urandom;
    pending_requests.push_back(q);
  endtask

  function automatic int rand_vec();
    return $urandom_range(0, 262144) - 131072;
  endfunction

  initial begin
    int mw, mh;
    sh_px = '0; sh_py = '0; sh_dx = 19'sd65536; sh_dy = '0;
    sh_plx = '0; sh_ply = 19'sd43253; sh_mw = 7'd64; sh_mh = 7'd64;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // every cell gets a defined value before the first cast
    for (int y = 0; y < MAP_DIM; y++)
      for (int x = 0; x < MAP_DIM; x++)
        queue_cell(x, y, $urandom_range(0, 99) < 10);
    drain_rays();

    // directed: screen edges, center ray with zero y component
    set_camera(32 * 65536 + 32768, 32 * 65536 + 32768, 65536, 0, 0, 43253, 64, 64);
    queue_cell(33, 32, 1'b1);
    queue_cast(0); queue_cast(512); queue_cast(1023); queue_cast(511); queue_cast(513);
    drain_rays();
    // extreme vectors, player at origin
    set_camera(0, 0, 131072, 131072, -131072, 131072, 64, 64);
    queue_cast(0); queue_cast(1023); queue_cast(700);
    drain_rays();
    set_camera(4194303, 4194303, -131072, -131072, 131072, 0, 64, 64);
    queue_cast(0); queue_cast(1023); queue_cast(256);
    drain_rays();
    // tiny, empty and oversized maps; player outside the map
    set_camera(0, 0, 65536, 65536, 0, 0, 1, 1);
    queue_cast(10); queue_cast(900);
    drain_rays();
    set_camera(5 * 65536, 5 * 65536, -65536, 0, 0, 65536, 0, 0);
    queue_cast(0); queue_cast(1023);
    drain_rays();
    set_camera(60 * 65536, 60 * 65536, -65536, -30000, 20000, 40000, 127, 127);
    queue_cast(100); queue_cast(800);
    drain_rays();
    set_camera(50 * 65536, 3 * 65536, -65536, 10000, 0, 43253, 10, 10);
    queue_cast(300); queue_cast(600); queue_cast(512);
    drain_rays();

    // random phases: mostly casts with some map rewrites
    for (int ph = 0; ph < 13; ph++) begin
      case (ph % 4)
        0: begin mw = 64; mh = 64; end
        1: begin mw = $urandom_range(1, 16); mh = $urandom_range(1, 16); end
        2: begin mw = $urandom_range(0, 127); mh = $urandom_range(0, 127); end
        default: begin mw = $urandom_range(1, 64); mh = $urandom_range(1, 64); end
      endcase
      if (ph % 5 == 4)
        set_camera($urandom_range(0, 4194303), $urandom_range(0, 4194303),
                   rand_vec(), rand_vec(), rand_vec(), rand_vec(), mw, mh);
      else
        set_camera($urandom_range(0, (mw > 0 && mw < 64 ? mw : 64) * 65536 - 1),
                   $urandom_range(0, (mh > 0 && mh < 64 ? mh : 64) * 65536 - 1),
                   rand_vec(), rand_vec(), rand_vec(), rand_vec(), mw, mh);
      for (int k = 0; k < 135; k++) begin
        if ($urandom_range(0, 99) < 15)
          queue_cell($urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 99) < 12);
        else
          queue_cast($urandom_range(0, 1023));
      end
      drain_rays();
    end

    $display("run covered %0d casts (%0d hits) and %0d cell writes", casts_taken,
             hits_seen, cell_writes);
    $display("results checked: %0d, field errors: %0d", rays_checked, errors);
    if (errors == 0 && due_rays.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/gdr_pkg.sv
rtl/gdr_ram.sv
rtl/gdr_div.sv
rtl/gdr_regs.sv
rtl/grid_dda_raycaster.sv
rtl/gdr_checker.sv
tb/grid_dda_raycaster_test.sv
